// ----- design/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the battery power sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int unsigned CNT_W   = 8;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] HOLD_TICKS_RST   = 8'd80;
    localparam logic [CFG_W-1:0] PULSE_TICKS_RST  = 8'd10;
    localparam logic [CFG_W-1:0] SETTLE_TICKS_RST = 8'd10;
    localparam logic [CNT_W-1:0] CNT_MAX          = 8'd255;

    // sequencer phases, encoded as reported on phase_code
    typedef enum logic [2:0] {
        PH_CHECK   = 3'd0,
        PH_STOPPED = 3'd1,
        PH_WAITLO  = 3'd2,
        PH_UPPULSE = 3'd3,
        PH_RUN     = 3'd4,
        PH_DNPULSE = 3'd5,
        PH_WAITHI  = 3'd6,
        PH_SETTLE  = 3'd7
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TICKS   = 2'd0,
        CFG_PULSE_TICKS  = 2'd1,
        CFG_SETTLE_TICKS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] pulse_ticks;
        logic [CFG_W-1:0] settle_ticks;
    } cfg_t;

    // one sampled tick
    typedef struct packed {
        logic pwr_button_level;
        logic peo_button_level;
        logic ps_on_level;
    } tick_t;

    // one status item
    typedef struct packed {
        logic   en_dcdc;
        logic   en_lcd;
        logic   en_peo;
        logic   peo_led;
        logic   host_switch_n;
        phase_t phase_code;
        logic   forced_off;
    } result_t;

endpackage

`default_nettype wire

// ----- design/bps_tick_if.sv -----
// ----------------------------------------------------------------------------
// bps_tick_if
// Valid/ready channel carrying one sampled tick of button and PS_ON levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_tick_if;
    logic valid;
    logic ready;
    logic pwr_button_level;
    logic peo_button_level;
    logic ps_on_level;

    modport source (
        output valid,
        output pwr_button_level,
        output peo_button_level,
        output ps_on_level,
        input  ready
    );

    modport sink (
        input  valid,
        input  pwr_button_level,
        input  peo_button_level,
        input  ps_on_level,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/bps_status_if.sv -----
// ----------------------------------------------------------------------------
// bps_status_if
// Valid/ready channel carrying one status item of enables and phase.
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_status_if;
    logic       valid;
    logic       ready;
    logic       en_dcdc;
    logic       en_lcd;
    logic       en_peo;
    logic       peo_led;
    logic       host_switch_n;
    logic [2:0] phase_code;
    logic       forced_off;

    modport source (
        output valid,
        output en_dcdc,
        output en_lcd,
        output en_peo,
        output peo_led,
        output host_switch_n,
        output phase_code,
        output forced_off,
        input  ready
    );

    modport sink (
        input  valid,
        input  en_dcdc,
        input  en_lcd,
        input  en_peo,
        input  peo_led,
        input  host_switch_n,
        input  phase_code,
        input  forced_off,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/bps_core.sv -----
// ----------------------------------------------------------------------------
// bps_core
// Sequencer state and its per-tick update; presents the state after the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire bps_pkg::tick_t  tick_in,
    input  wire bps_pkg::cfg_t   cfg,
    output bps_pkg::result_t     res
);

    bps_pkg::phase_t                phase_reg, phase_next;
    logic [bps_pkg::CNT_W-1:0]      tick_cnt_reg, tick_cnt_next;
    logic [bps_pkg::CNT_W-1:0]      hold_cnt_reg, hold_cnt_next;
    logic                           sreq_reg, sreq_next;
    logic                           forced_reg, forced_next;
    logic                           sys_on_reg, sys_on_next;
    logic                           prev_peo_reg, prev_peo_next;
    logic                           prev_pwr_reg, prev_pwr_next;
    logic                           dcdc_reg, dcdc_next;
    logic                           lcd_reg, lcd_next;
    logic                           peo_reg, peo_next;
    logic                           led_reg, led_next;
    logic                           sw_reg, sw_next;

    logic pwr_edge;
    logic pulse_end;
    logic settle_end;
    logic hold_force;
    logic peo_watch;

    // button edge, pulse and settle end, forced shutdown test
    assign pwr_edge   = tick_in.pwr_button_level & ~prev_pwr_reg;
    assign pulse_end  = (tick_cnt_reg <= bps_pkg::CNT_W'(1));
    assign settle_end = pulse_end;
    assign hold_force = (hold_cnt_next >= cfg.hold_ticks);
    assign peo_watch  = ((phase_reg == bps_pkg::PH_WAITLO) ||
                         (phase_reg == bps_pkg::PH_UPPULSE) ||
                         (phase_reg == bps_pkg::PH_RUN)) && !sreq_reg;

    // hold counter: counts while pressed, saturates, clears on release
    always_comb
    begin
        if (tick_in.pwr_button_level)
        begin
            hold_cnt_next = '0;
        end
        else if (hold_cnt_reg != bps_pkg::CNT_MAX)
        begin
            hold_cnt_next = hold_cnt_reg + bps_pkg::CNT_W'(1);
        end
        else
        begin
            hold_cnt_next = hold_cnt_reg;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            bps_pkg::PH_CHECK:
            begin
                phase_next = tick_in.ps_on_level ? bps_pkg::PH_STOPPED : bps_pkg::PH_RUN;
            end
            bps_pkg::PH_STOPPED:
            begin
                if (pwr_edge)
                begin
                    phase_next = bps_pkg::PH_WAITLO;
                end
            end
            bps_pkg::PH_WAITLO:
            begin
                if (!tick_in.ps_on_level)
                begin
                    phase_next = bps_pkg::PH_UPPULSE;
                end
            end
            bps_pkg::PH_UPPULSE:
            begin
                if (pulse_end)
                begin
                    phase_next = bps_pkg::PH_RUN;
                end
            end
            bps_pkg::PH_RUN:
            begin
                if (hold_force)
                begin
                    phase_next = bps_pkg::PH_SETTLE;
                end
                else if (pwr_edge && sys_on_reg)
                begin
                    phase_next = bps_pkg::PH_DNPULSE;
                end
            end
            bps_pkg::PH_DNPULSE:
            begin
                if (pulse_end)
                begin
                    phase_next = bps_pkg::PH_WAITHI;
                end
            end
            bps_pkg::PH_WAITHI:
            begin
                if (tick_in.ps_on_level)
                begin
                    phase_next = bps_pkg::PH_SETTLE;
                end
            end
            bps_pkg::PH_SETTLE:
            begin
                if (settle_end)
                begin
                    phase_next = bps_pkg::PH_CHECK;
                end
            end
            default:
            begin
                phase_next = bps_pkg::PH_CHECK;
            end
        endcase
    end

    // counters, flags and output bits
    always_comb
    begin
        tick_cnt_next = tick_cnt_reg;
        sreq_next     = sreq_reg;
        forced_next   = forced_reg;
        sys_on_next   = sys_on_reg;
        prev_peo_next = prev_peo_reg;
        prev_pwr_next = tick_in.pwr_button_level;
        dcdc_next     = dcdc_reg;
        lcd_next      = lcd_reg;
        peo_next      = peo_reg;
        led_next      = led_reg;
        sw_next       = sw_reg;

        // peo button change toggles peo power and led
        if (peo_watch)
        begin
            if (tick_in.peo_button_level != prev_peo_reg)
            begin
                peo_next = ~peo_reg;
                led_next = ~led_reg;
            end
            prev_peo_next = tick_in.peo_button_level;
        end

        unique case (phase_reg)
            bps_pkg::PH_CHECK:
            begin
                if (!tick_in.ps_on_level)
                begin
                    sys_on_next = 1'b1;
                end
            end
            bps_pkg::PH_STOPPED:
            begin
                if (pwr_edge)
                begin
                    prev_peo_next = tick_in.peo_button_level;
                    dcdc_next     = 1'b1;
                end
            end
            bps_pkg::PH_WAITLO:
            begin
                if (!tick_in.ps_on_level)
                begin
                    tick_cnt_next = cfg.pulse_ticks;
                    sw_next       = 1'b0;
                end
            end
            bps_pkg::PH_UPPULSE:
            begin
                if (pulse_end)
                begin
                    tick_cnt_next = '0;
                    sw_next       = 1'b1;
                    lcd_next      = 1'b1;
                    sys_on_next   = 1'b1;
                end
                else
                begin
                    tick_cnt_next = tick_cnt_reg - bps_pkg::CNT_W'(1);
                end
            end
            bps_pkg::PH_RUN:
            begin
                if (hold_force)
                begin
                    sreq_next     = 1'b1;
                    forced_next   = 1'b1;
                    dcdc_next     = 1'b0;
                    lcd_next      = 1'b0;
                    peo_next      = 1'b0;
                    led_next      = 1'b0;
                    sw_next       = 1'b1;
                    sys_on_next   = 1'b0;
                    tick_cnt_next = cfg.settle_ticks;
                end
                else if (pwr_edge && sys_on_reg)
                begin
                    sreq_next     = 1'b1;
                    tick_cnt_next = cfg.pulse_ticks;
                    sw_next       = 1'b0;
                end
            end
            bps_pkg::PH_DNPULSE:
            begin
                if (pulse_end)
                begin
                    tick_cnt_next = '0;
                    sw_next       = 1'b1;
                end
                else
                begin
                    tick_cnt_next = tick_cnt_reg - bps_pkg::CNT_W'(1);
                end
            end
            bps_pkg::PH_WAITHI:
            begin
                if (tick_in.ps_on_level)
                begin
                    dcdc_next     = 1'b0;
                    lcd_next      = 1'b0;
                    peo_next      = 1'b0;
                    led_next      = 1'b0;
                    sw_next       = 1'b1;
                    sys_on_next   = 1'b0;
                    tick_cnt_next = cfg.settle_ticks;
                end
            end
            bps_pkg::PH_SETTLE:
            begin
                if (!settle_end)
                begin
                    tick_cnt_next = tick_cnt_reg - bps_pkg::CNT_W'(1);
                end
                else
                begin
                    tick_cnt_next = '0;
                    sreq_next     = 1'b0;
                    forced_next   = 1'b0;
                end
            end
            default:
            begin
                tick_cnt_next = tick_cnt_reg;
            end
        endcase
    end

    // state registers, advanced once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= bps_pkg::PH_CHECK;
            tick_cnt_reg <= '0;
            hold_cnt_reg <= '0;
            sreq_reg     <= 1'b0;
            forced_reg   <= 1'b0;
            sys_on_reg   <= 1'b0;
            prev_peo_reg <= 1'b0;
            prev_pwr_reg <= 1'b1;
            dcdc_reg     <= 1'b0;
            lcd_reg      <= 1'b0;
            peo_reg      <= 1'b0;
            led_reg      <= 1'b0;
            sw_reg       <= 1'b1;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_cnt_reg <= tick_cnt_next;
            // settle end also clears the hold count
            hold_cnt_reg <= ((phase_reg == bps_pkg::PH_SETTLE) && settle_end) ?
                            '0 : hold_cnt_next;
            sreq_reg     <= sreq_next;
            forced_reg   <= forced_next;
            sys_on_reg   <= sys_on_next;
            prev_peo_reg <= prev_peo_next;
            prev_pwr_reg <= prev_pwr_next;
            dcdc_reg     <= dcdc_next;
            lcd_reg      <= lcd_next;
            peo_reg      <= peo_next;
            led_reg      <= led_next;
            sw_reg       <= sw_next;
        end
    end

    // status after this tick
    always_comb
    begin
        res.en_dcdc       = dcdc_next;
        res.en_lcd        = lcd_next;
        res.en_peo        = peo_next;
        res.peo_led       = led_next;
        res.host_switch_n = sw_next;
        res.phase_code    = phase_next;
        res.forced_off    = forced_next;
    end

endmodule

`default_nettype wire

// ----- design/battery_power_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// battery_power_sequencer_unit
// Tick-driven power sequencer for a battery-powered host with LCD and PEO.
// ----------------------------------------------------------------------------
// Each accepted item is one 50 ms tick of sampled button and PS_ON levels and
// yields exactly one status item showing enables, switch line, phase and the
// forced-shutdown flag after that tick. A tick passes an input register, then
// the sequencer logic that updates the state and loads the status register,
// which drives the status item; a status item not yet accepted holds the
// tick in the input register. One tick is taken every clock cycle as long as
// the status side keeps up. Registers hold_ticks, pulse_ticks and
// settle_ticks are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no tick is in flight, which the block does not
// enforce. They reset to 80, 10 and 10.
`default_nettype none

module battery_power_sequencer_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bps_pkg::CFG_W-1:0]          cfg_data,
    bps_tick_if.sink                                tick,
    bps_status_if.source                            status
);

    bps_pkg::cfg_t    cfg_reg;
    bps_pkg::tick_t   in_reg;
    logic             in_vld_reg, in_vld_next;
    bps_pkg::result_t out_reg;
    logic             out_vld_reg, out_vld_next;
    bps_pkg::result_t core_res;
    logic             advance;
    logic             take;

    // pipeline handshake
    assign advance    = in_vld_reg && (!out_vld_reg || status.ready);
    assign tick.ready = !in_vld_reg || advance;
    assign take       = tick.valid && tick.ready;

    always_comb
    begin
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end

        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks   <= bps_pkg::HOLD_TICKS_RST;
            cfg_reg.pulse_ticks  <= bps_pkg::PULSE_TICKS_RST;
            cfg_reg.settle_ticks <= bps_pkg::SETTLE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bps_pkg::CFG_HOLD_TICKS:   cfg_reg.hold_ticks   <= cfg_data;
                bps_pkg::CFG_PULSE_TICKS:  cfg_reg.pulse_ticks  <= cfg_data;
                bps_pkg::CFG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input and status payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.pwr_button_level <= tick.pwr_button_level;
            in_reg.peo_button_level <= tick.peo_button_level;
            in_reg.ps_on_level      <= tick.ps_on_level;
        end
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    // sequencer
    bps_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .tick_in (in_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    // status channel
    assign status.valid         = out_vld_reg;
    assign status.en_dcdc       = out_reg.en_dcdc;
    assign status.en_lcd        = out_reg.en_lcd;
    assign status.en_peo        = out_reg.en_peo;
    assign status.peo_led       = out_reg.peo_led;
    assign status.host_switch_n = out_reg.host_switch_n;
    assign status.phase_code    = out_reg.phase_code;
    assign status.forced_off    = out_reg.forced_off;

endmodule

`default_nettype wire
